// ===== design/cblm_pkg.sv =====
package cblm_pkg;

  localparam int unsigned KindBits = 3;
  localparam int unsigned AttrBits = 2;
  localparam int unsigned JobBits  = 2;
  localparam int unsigned StepBits = 2;

  typedef enum logic [KindBits-1:0] {
    KIND_IF      = 3'd0,
    KIND_ENDIF   = 3'd1,
    KIND_LOOP    = 3'd2,
    KIND_ENDLOOP = 3'd3
  } layer_kind_e;

  typedef enum logic [AttrBits-1:0] {
    ATTR_OWNER_IF   = 2'd0,
    ATTR_ELSE_START = 2'd1,
    ATTR_IS_ELSE    = 2'd2,
    ATTR_GOTO       = 2'd3
  } attr_e;

  typedef enum logic [JobBits-1:0] {
    JOB_ERR  = 2'd0,
    JOB_THEN = 2'd1,
    JOB_ELSE = 2'd2,
    JOB_LOOP = 2'd3
  } job_kind_e;

  function automatic logic [StepBits-1:0] last_step(job_kind_e kind);
    logic [StepBits-1:0] s;
    case (kind)
      JOB_THEN: s = 2'd2;
      JOB_ELSE: s = 2'd3;
      JOB_LOOP: s = 2'd1;
      default:  s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/cblm_stack.sv =====
module cblm_stack #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          pop_i,
  input  logic          set_i,
  input  logic [DW-1:0] data_i,
  output logic [DW-1:0] top_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] top_q;
  logic [DW-1:0] below_q;
  logic [DW-1:0] mem_q [DEPTH];
  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_cnt  = count_q - CW'(1);
  assign rd_cnt  = count_q - CW'(3);
  assign wr_addr = wr_cnt[AW-1:0];
  assign rd_addr = rd_cnt[AW-1:0];

  assign top_o   = top_q;
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (count_q != '0)) begin
      mem_q[wr_addr] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      top_q   <= data_i;
      below_q <= top_q;
    end else if (pop_i) begin
      top_q   <= below_q;
      below_q <= mem_q[rd_addr];
    end else if (set_i) begin
      top_q   <= data_i;
    end
  end

endmodule

// ===== design/cblm_fifo.sv =====
module cblm_fifo #(
  parameter int unsigned W = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         wr_en, rd_en;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign wr_en       = in_valid_i && in_ready_o;
  assign rd_en       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/cblm_front.sv =====
module cblm_front import cblm_pkg::*; #(
  parameter int unsigned NEST_DEPTH = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KindBits-1:0] layer_kind_i,
  input  logic [ID_BITS-1:0]  layer_id_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output job_kind_e           job_kind_o,
  output logic [ID_BITS-1:0]  job_id_o,
  output logic [ID_BITS-1:0]  job_a_o,
  output logic [ID_BITS-1:0]  job_b_o
);

  logic               accept;
  logic               has_job;

  logic               if_push, if_pop, if_set, if_empty, if_full;
  logic [ID_BITS:0]   if_wdata, if_top;
  logic               te_push, te_pop, te_empty, te_full;
  logic [ID_BITS-1:0] te_top;
  logic               lp_push, lp_pop, lp_empty, lp_full;
  logic [ID_BITS-1:0] lp_top;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = in_valid_i && has_job;
  assign job_id_o    = layer_id_i;

  always_comb begin
    has_job    = 1'b0;
    job_kind_o = JOB_ERR;
    job_a_o    = '0;
    job_b_o    = '0;
    if_push    = 1'b0;
    if_pop     = 1'b0;
    if_set     = 1'b0;
    if_wdata   = {1'b1, layer_id_i};
    te_push    = 1'b0;
    te_pop     = 1'b0;
    lp_push    = 1'b0;
    lp_pop     = 1'b0;
    case (layer_kind_e'(layer_kind_i))
      KIND_IF: begin
        if (if_full) begin
          has_job = 1'b1;
        end else begin
          if_push = accept;
        end
      end
      KIND_ENDIF: begin
        if (if_empty) begin
          has_job = 1'b1;
        end else if (if_top[ID_BITS]) begin
          has_job = 1'b1;
          if (!te_full) begin
            job_kind_o = JOB_THEN;
            job_a_o    = if_top[ID_BITS-1:0];
            te_push    = accept;
            if_set     = accept;
            if_wdata   = {1'b0, if_top[ID_BITS-1:0]};
          end
        end else begin
          has_job = 1'b1;
          if (!te_empty) begin
            job_kind_o = JOB_ELSE;
            job_a_o    = if_top[ID_BITS-1:0];
            job_b_o    = te_top;
            te_pop     = accept;
            if_pop     = accept;
          end
        end
      end
      KIND_LOOP: begin
        if (lp_full) begin
          has_job = 1'b1;
        end else begin
          lp_push = accept;
        end
      end
      KIND_ENDLOOP: begin
        has_job = 1'b1;
        if (!lp_empty) begin
          job_kind_o = JOB_LOOP;
          job_a_o    = lp_top;
          lp_pop     = accept;
        end
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  cblm_stack #(
    .DW    (ID_BITS + 1),
    .DEPTH (NEST_DEPTH)
  ) u_if_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (if_push),
    .pop_i   (if_pop),
    .set_i   (if_set),
    .data_i  (if_wdata),
    .top_o   (if_top),
    .empty_o (if_empty),
    .full_o  (if_full)
  );

  cblm_stack #(
    .DW    (ID_BITS),
    .DEPTH (NEST_DEPTH)
  ) u_then_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (te_push),
    .pop_i   (te_pop),
    .set_i   (1'b0),
    .data_i  (layer_id_i),
    .top_o   (te_top),
    .empty_o (te_empty),
    .full_o  (te_full)
  );

  cblm_stack #(
    .DW    (ID_BITS),
    .DEPTH (NEST_DEPTH)
  ) u_loop_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lp_push),
    .pop_i   (lp_pop),
    .set_i   (1'b0),
    .data_i  (layer_id_i),
    .top_o   (lp_top),
    .empty_o (lp_empty),
    .full_o  (lp_full)
  );

endmodule

// ===== design/cblm_back.sv =====
module cblm_back import cblm_pkg::*; #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  job_kind_e           job_kind_i,
  input  logic [ID_BITS-1:0]  job_id_i,
  input  logic [ID_BITS-1:0]  job_a_i,
  input  logic [ID_BITS-1:0]  job_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ID_BITS-1:0]  target_layer_o,
  output logic [AttrBits-1:0] attribute_o,
  output logic [ID_BITS-1:0]  attr_value_o,
  output logic                last_write_o,
  output logic                nesting_error_o
);

  logic                busy_q;
  logic [StepBits-1:0] step_q;
  job_kind_e           kind_q;
  logic [ID_BITS-1:0]  id_q, a_q, b_q;
  logic [ID_BITS-1:0]  next_id;
  logic                is_last;
  logic                take;
  attr_e               attr;

  assign next_id      = id_q + ID_BITS'(1);
  assign is_last      = (step_q == last_step(kind_q));
  assign take         = !busy_q || (out_ready_i && is_last);
  assign job_ready_o  = take;
  assign out_valid_o  = busy_q;
  assign attribute_o  = attr;
  assign last_write_o = is_last && (kind_q != JOB_ERR);

  always_comb begin
    target_layer_o  = id_q;
    attr            = ATTR_OWNER_IF;
    attr_value_o    = a_q;
    nesting_error_o = 1'b0;
    case (kind_q)
      JOB_THEN: begin
        case (step_q)
          2'd0: begin
            attr = ATTR_OWNER_IF;
          end
          2'd1: begin
            target_layer_o = a_q;
            attr           = ATTR_ELSE_START;
            attr_value_o   = next_id;
          end
          default: begin
            attr         = ATTR_IS_ELSE;
            attr_value_o = '0;
          end
        endcase
      end
      JOB_ELSE: begin
        case (step_q)
          2'd0: begin
            attr = ATTR_OWNER_IF;
          end
          2'd1: begin
            target_layer_o = b_q;
            attr           = ATTR_GOTO;
            attr_value_o   = id_q;
          end
          2'd2: begin
            attr         = ATTR_GOTO;
            attr_value_o = next_id;
          end
          default: begin
            attr         = ATTR_IS_ELSE;
            attr_value_o = ID_BITS'(1);
          end
        endcase
      end
      JOB_LOOP: begin
        attr = ATTR_GOTO;
        if (step_q != 2'd0) begin
          target_layer_o = a_q;
          attr_value_o   = next_id;
        end
      end
      default: begin
        target_layer_o  = '0;
        attr            = ATTR_OWNER_IF;
        attr_value_o    = '0;
        nesting_error_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (job_valid_i && take) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q && out_ready_i) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && take) begin
      kind_q <= job_kind_i;
      id_q   <= job_id_i;
      a_q    <= job_a_i;
      b_q    <= job_b_i;
    end
  end

endmodule

// ===== design/control_block_link_matcher.sv =====
// Endif and endloop jobs pass the job queue, then are registered in the back end for output.
// Throughput: one input transfer per cycle while the two-entry job queue has room.
// Results leave one per cycle while out_ready_i is high: endif gives 3 or 4, endloop 2, error 1;
// if and loop layers give an error result only when their stack is full; other layers give none.
// Reset: stack counts, queue and output valid clear; stack contents stay undefined.
module control_block_link_matcher import cblm_pkg::*; #(
  parameter int unsigned NEST_DEPTH = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KindBits-1:0] layer_kind_i,
  input  logic [ID_BITS-1:0]  layer_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ID_BITS-1:0]  target_layer_o,
  output logic [AttrBits-1:0] attribute_o,
  output logic [ID_BITS-1:0]  attr_value_o,
  output logic                last_write_o,
  output logic                nesting_error_o
);

  localparam int unsigned JW = JobBits + 3 * ID_BITS;

  logic               fj_valid, fj_ready;
  job_kind_e          fj_kind;
  logic [ID_BITS-1:0] fj_id, fj_a, fj_b;
  logic               bj_valid, bj_ready;
  logic [JW-1:0]      fj_data, bj_data;

  assign fj_data = {fj_kind, fj_id, fj_a, fj_b};

  cblm_front #(
    .NEST_DEPTH (NEST_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .layer_kind_i (layer_kind_i),
    .layer_id_i   (layer_id_i),
    .job_valid_o  (fj_valid),
    .job_ready_i  (fj_ready),
    .job_kind_o   (fj_kind),
    .job_id_o     (fj_id),
    .job_a_o      (fj_a),
    .job_b_o      (fj_b)
  );

  cblm_fifo #(
    .W (JW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fj_valid),
    .in_ready_o  (fj_ready),
    .in_data_i   (fj_data),
    .out_valid_o (bj_valid),
    .out_ready_i (bj_ready),
    .out_data_o  (bj_data)
  );

  cblm_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (bj_valid),
    .job_ready_o     (bj_ready),
    .job_kind_i      (job_kind_e'(bj_data[JW-1 -: JobBits])),
    .job_id_i        (bj_data[3*ID_BITS-1 -: ID_BITS]),
    .job_a_i         (bj_data[2*ID_BITS-1 -: ID_BITS]),
    .job_b_i         (bj_data[ID_BITS-1:0]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .target_layer_o  (target_layer_o),
    .attribute_o     (attribute_o),
    .attr_value_o    (attr_value_o),
    .last_write_o    (last_write_o),
    .nesting_error_o (nesting_error_o)
  );

endmodule

// ===== design/cblm_checker.sv =====
module cblm_checker import cblm_pkg::*; #(
  parameter int unsigned ID_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [ID_BITS-1:0]  target_layer_i,
  input logic [AttrBits-1:0] attribute_i,
  input logic [ID_BITS-1:0]  attr_value_i,
  input logic                last_write_i,
  input logic                nesting_error_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before transfer");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && nesting_error_i |->
      target_layer_i == '0 && attribute_i == ATTR_OWNER_IF &&
      attr_value_i == '0 && !last_write_i)
    else $error("error result carries nonzero fields");

  a_last_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_write_i |->
      attribute_i == ATTR_IS_ELSE || attribute_i == ATTR_GOTO)
    else $error("final write has unexpected attribute");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_write_i && !nesting_error_i |=> out_valid_i)
    else $error("gap inside a write burst");

endmodule

bind control_block_link_matcher cblm_checker #(
  .ID_BITS (ID_BITS)
) u_cblm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .target_layer_i  (target_layer_o),
  .attribute_i     (attribute_o),
  .attr_value_i    (attr_value_o),
  .last_write_i    (last_write_o),
  .nesting_error_i (nesting_error_o)
);
